// ===== design/gis_pkg.sv =====
package gis_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int MAX_NEIGHBORS = 8;
    localparam int NUM_LISTS     = 3;

    // Port field widths
    localparam int CMD_W    = 2;
    localparam int POINT_W  = 10;
    localparam int SLOTF_W  = 3;
    localparam int LIST_W   = 2;
    localparam int NBI_W    = 10;
    localparam int STATUS_W = 2;
    localparam int PIU_W    = 11;
    localparam int NIU_W    = 4;
    localparam int CFG_DW   = 11;
    localparam int CFG_IW   = 1;

    // Derived storage widths
    localparam int PT_W     = $clog2(MAX_POINTS);
    localparam int SLOT_W   = $clog2(MAX_NEIGHBORS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int NBC_W    = $clog2(MAX_NEIGHBORS + 1);
    localparam int NB_DEPTH = NUM_LISTS * MAX_POINTS * MAX_NEIGHBORS;
    localparam int NB_AW    = $clog2(NB_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_VISIT = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] MARK_UNVISITED      = 2'd0;
    localparam logic [STATUS_W-1:0] MARK_SELECTED       = 2'd1;
    localparam logic [STATUS_W-1:0] MARK_REJECTED       = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd3;

    localparam logic [CFG_IW-1:0] REG_POINTS_IN_USE    = 1'd0;
    localparam logic [CFG_IW-1:0] REG_NEIGHBORS_IN_USE = 1'd1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_SEL,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

// ===== design/greedy_independent_sample_select.sv =====
// Greedy independent sample selection.
// Input channel (in_valid/in_ready) takes one command per transfer: load a
// neighbour entry, clear all marks in use, visit a point, or read a mark.
// Every command gives exactly one result on the output channel
// (out_valid/out_ready): the point, its mark after the command, and a flag
// set when a visit selected the point.
// A clear sweeps min(points_in_use, 1024) mark entries; a visit of an unvisited
// point looks up the entry of every list at each of the k effective
// neighbors_in_use slots. The single read port of the mark memory sets the
// pace: one neighbour mark is looked up per cycle, pipelined behind the
// neighbour memory read, with the previous cycle's reject write forwarded.
// After reset the mark memory is swept to unvisited, one entry a cycle;
// in_ready stays low until it finishes. Config writes take effect at once
// and must only be made while no command is in flight.
// The result sits in an output register; when the receiver stalls the block
// finishes the current command, then holds it and takes no new command until
// the output register is free.
module greedy_independent_sample_select
    import gis_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [POINT_W-1:0]  point,
    input  logic [SLOTF_W-1:0]  slot,
    input  logic [LIST_W-1:0]   list_select,
    input  logic [NBI_W-1:0]    neighbor_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POINT_W-1:0]  point_echo,
    output logic [STATUS_W-1:0] status,
    output logic                newly_selected,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [PIU_W-1:0] points_in_use_reg;
    logic [NIU_W-1:0] neighbors_in_use_reg;

    cmd_t               cmd_reg, cmd_next;
    logic [POINT_W-1:0] point_reg, point_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_newly_reg, res_newly_next;

    logic                out_valid_reg, out_valid_next;
    logic [POINT_W-1:0]  out_point_reg, out_point_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_newly_reg, out_newly_next;

    logic [PT_W-1:0] cnt_reg, cnt_next;

    logic              issue_busy_reg, issue_busy_next;
    logic [LIST_W-1:0] lst_reg, lst_next;
    logic [SLOT_W-1:0] slt_reg, slt_next;

    logic            s1_valid_reg, s1_valid_next;
    logic            s2_valid_reg, s2_valid_next;
    logic            s2_ok_reg, s2_ok_next;
    logic [PT_W-1:0] s2_nb_reg, s2_nb_next;

    logic            fwd_valid_reg, fwd_valid_next;
    logic [PT_W-1:0] fwd_addr_reg, fwd_addr_next;

    logic [CNT_W-1:0] n_eff;
    logic [NBC_W-1:0] k_eff;
    logic             pt_in_range;
    logic             out_free;

    logic             nb_we;
    logic [NB_AW-1:0] nb_waddr, nb_raddr;
    logic [NBI_W-1:0] nb_wdata, nb_rdata;

    logic                mark_we;
    logic [PT_W-1:0]     mark_waddr, mark_raddr;
    logic [STATUS_W-1:0] mark_wdata, mark_rdata;

    gis_ram #(
        .WIDTH (NBI_W),
        .DEPTH (NB_DEPTH)
    ) u_nb_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wdata),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    gis_ram #(
        .WIDTH (STATUS_W),
        .DEPTH (MAX_POINTS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign n_eff = (CNT_W'(points_in_use_reg) < CNT_W'(MAX_POINTS)) ?
                   CNT_W'(points_in_use_reg) : CNT_W'(MAX_POINTS);
    assign k_eff = (NBC_W'(neighbors_in_use_reg) < NBC_W'(MAX_NEIGHBORS)) ?
                   NBC_W'(neighbors_in_use_reg) : NBC_W'(MAX_NEIGHBORS);

    assign pt_in_range = CNT_W'(point) < n_eff;
    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == ST_IDLE);

    assign out_valid      = out_valid_reg;
    assign point_echo     = out_point_reg;
    assign status         = out_status_reg;
    assign newly_selected = out_newly_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (cnt_reg == PT_W'(MAX_POINTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!pt_in_range)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cmd_t'(cmd) == CMD_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                if (cmd_reg == CMD_VISIT && mark_rdata == MARK_UNVISITED)
                begin
                    state_next = (k_eff == '0) ? ST_SEL : ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (!issue_busy_reg && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (CNT_W'(cnt_reg) + CNT_W'(1) == n_eff)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next        = cmd_reg;
        point_next      = point_reg;
        res_status_next = res_status_reg;
        res_newly_next  = res_newly_reg;
        cnt_next        = cnt_reg;
        issue_busy_next = issue_busy_reg;
        lst_next        = lst_reg;
        slt_next        = slt_reg;
        s1_valid_next   = 1'b0;
        s2_valid_next   = 1'b0;
        s2_ok_next      = s2_ok_reg;
        s2_nb_next      = s2_nb_reg;
        fwd_valid_next  = 1'b0;
        fwd_addr_next   = fwd_addr_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_point_next  = out_point_reg;
        out_status_next = out_status_reg;
        out_newly_next  = out_newly_reg;

        nb_we      = 1'b0;
        nb_waddr   = NB_AW'({list_select, point[PT_W-1:0], slot[SLOT_W-1:0]});
        nb_wdata   = neighbor_index;
        nb_raddr   = NB_AW'({lst_reg, point_reg[PT_W-1:0], slt_reg});
        mark_we    = 1'b0;
        mark_waddr = point_reg[PT_W-1:0];
        mark_wdata = MARK_UNVISITED;
        mark_raddr = point[PT_W-1:0];

        unique case (state_reg)
            ST_INIT:
            begin
                mark_we    = 1'b1;
                mark_waddr = cnt_reg;
                cnt_next   = cnt_reg + PT_W'(1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd_t'(cmd);
                    point_next      = point;
                    cnt_next        = '0;
                    res_newly_next  = 1'b0;
                    res_status_next = MARK_UNVISITED;
                    if (!pt_in_range)
                    begin
                        res_status_next = STATUS_OUT_OF_RANGE;
                    end
                    else if (cmd_t'(cmd) == CMD_LOAD)
                    begin
                        nb_we = (32'(slot) < MAX_NEIGHBORS) && (32'(list_select) < NUM_LISTS);
                    end
                end
            end
            ST_MARK:
            begin
                res_status_next = mark_rdata;
                lst_next        = '0;
                slt_next        = '0;
                if (cmd_reg == CMD_VISIT && mark_rdata == MARK_UNVISITED)
                begin
                    issue_busy_next = (k_eff != '0);
                end
            end
            ST_SCAN:
            begin
                // stage 0: neighbour entry read
                if (issue_busy_reg)
                begin
                    s1_valid_next = 1'b1;
                    if (lst_reg == LIST_W'(NUM_LISTS - 1))
                    begin
                        lst_next = '0;
                        if (NBC_W'(slt_reg) + NBC_W'(1) == k_eff)
                        begin
                            issue_busy_next = 1'b0;
                        end
                        else
                        begin
                            slt_next = slt_reg + SLOT_W'(1);
                        end
                    end
                    else
                    begin
                        lst_next = lst_reg + LIST_W'(1);
                    end
                end
                // stage 1: neighbour's mark read
                if (s1_valid_reg)
                begin
                    mark_raddr    = nb_rdata[PT_W-1:0];
                    s2_valid_next = 1'b1;
                    s2_nb_next    = nb_rdata[PT_W-1:0];
                    s2_ok_next    = CNT_W'(nb_rdata) < n_eff;
                end
                // stage 2: reject; last cycle's write is not yet in the read data
                if (s2_valid_reg && s2_ok_reg && mark_rdata == MARK_UNVISITED &&
                    !(fwd_valid_reg && fwd_addr_reg == s2_nb_reg))
                begin
                    mark_we        = 1'b1;
                    mark_waddr     = s2_nb_reg;
                    mark_wdata     = MARK_REJECTED;
                    fwd_valid_next = 1'b1;
                    fwd_addr_next  = s2_nb_reg;
                end
            end
            ST_SEL:
            begin
                mark_we         = 1'b1;
                mark_wdata      = MARK_SELECTED;
                res_status_next = MARK_SELECTED;
                res_newly_next  = 1'b1;
            end
            ST_CLEAR:
            begin
                mark_we    = 1'b1;
                mark_waddr = cnt_reg;
                cnt_next   = cnt_reg + PT_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_point_next  = point_reg;
                    out_status_next = res_status_reg;
                    out_newly_next  = res_newly_reg;
                end
            end
            default:
            begin
                mark_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_INIT;
            points_in_use_reg    <= PIU_W'(MAX_POINTS);
            neighbors_in_use_reg <= NIU_W'(MAX_NEIGHBORS);
            cnt_reg              <= '0;
            out_valid_reg        <= 1'b0;
            issue_busy_reg       <= 1'b0;
            s1_valid_reg         <= 1'b0;
            s2_valid_reg         <= 1'b0;
            fwd_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            issue_busy_reg <= issue_busy_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POINTS_IN_USE:
                    begin
                        points_in_use_reg <= cfg_data[PIU_W-1:0];
                    end
                    REG_NEIGHBORS_IN_USE:
                    begin
                        neighbors_in_use_reg <= cfg_data[NIU_W-1:0];
                    end
                    default:
                    begin
                        points_in_use_reg <= points_in_use_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        point_reg      <= point_next;
        res_status_reg <= res_status_next;
        res_newly_reg  <= res_newly_next;
        out_point_reg  <= out_point_next;
        out_status_reg <= out_status_next;
        out_newly_reg  <= out_newly_next;
        lst_reg        <= lst_next;
        slt_reg        <= slt_next;
        s2_ok_reg      <= s2_ok_next;
        s2_nb_reg      <= s2_nb_next;
        fwd_addr_reg   <= fwd_addr_next;
    end

    // a neighbour listed twice in a row must not be rejected twice
    a_no_double_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_we && mark_wdata == MARK_REJECTED) |=>
        !(mark_we && mark_wdata == MARK_REJECTED && mark_waddr == $past(mark_waddr)))
        else $error("back-to-back reject of the same point");

    a_newly_is_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_newly_reg) |-> (out_status_reg == MARK_SELECTED))
        else $error("newly selected result without selected status");

    a_idle_no_mark_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mark_we)
        else $error("mark memory written while idle");

    a_select_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL) |-> (!issue_busy_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("select written with neighbour scan still in flight");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result transfer raised outside the done state");

endmodule

// ===== design/gis_ram.sv =====
module gis_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read during write at the same address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== dv/tb_greedy_independent_sample_select.sv =====
module tb_greedy_independent_sample_select
    import gis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SRC  = 1;
    localparam int IDLE_SINK = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        logic [POINT_W-1:0]  pt;
        logic [STATUS_W-1:0] mark;
        logic                picked;
    } mark_report_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    cmd_t                cmd;
    logic [POINT_W-1:0]  point;
    logic [SLOTF_W-1:0]  slot;
    logic [LIST_W-1:0]   list_select;
    logic [NBI_W-1:0]    neighbor_index;
    logic                out_valid;
    logic                out_ready;
    logic [POINT_W-1:0]  point_echo;
    logic [STATUS_W-1:0] status;
    logic                newly_selected;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    // Shadow of the block's state
    logic [STATUS_W-1:0] mark_mem [MAX_POINTS];
    logic [NBI_W-1:0]    nbr_mem [NUM_LISTS][MAX_POINTS][MAX_NEIGHBORS];
    bit                  nbr_written [NUM_LISTS][MAX_POINTS][MAX_NEIGHBORS];
    logic [PIU_W-1:0]    pts_cfg;
    logic [NIU_W-1:0]    nbrs_cfg;

    mark_report_t        pending_marks [$];
    mark_report_t        want;
    int                  errors;
    int                  items_sent;
    int                  src_idle_pct;
    int                  sink_stall_pct;

    greedy_independent_sample_select u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .point          (point),
        .slot           (slot),
        .list_select    (list_select),
        .neighbor_index (neighbor_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_echo     (point_echo),
        .status         (status),
        .newly_selected (newly_selected),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("greedy_independent_sample_select verification failed");
        $finish;
    end

    function automatic int eff_points();
        return (pts_cfg > MAX_POINTS) ? MAX_POINTS : int'(pts_cfg);
    endfunction

    function automatic int eff_nbrs();
        return (nbrs_cfg > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(nbrs_cfg);
    endfunction

    // Applies one command to the shadow state and queues the mark it reports
    function automatic void update_marks(input cmd_t c, input int p, input int s,
                                         input int l, input int nb);
        int n;
        int k;
        int q;
        mark_report_t r;
        n = eff_points();
        k = eff_nbrs();
        r.pt = p[POINT_W-1:0];
        r.picked = 1'b0;
        if (p >= n)
        begin
            r.mark = STATUS_OUT_OF_RANGE;
        end
        else
        begin
            case (c)
                CMD_LOAD:
                begin
                    if (l < NUM_LISTS)
                    begin
                        nbr_mem[l][p][s] = nb[NBI_W-1:0];
                        nbr_written[l][p][s] = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    for (int i = 0; i < n; i++)
                        mark_mem[i] = MARK_UNVISITED;
                end
                CMD_VISIT:
                begin
                    if (mark_mem[p] == MARK_UNVISITED)
                    begin
                        for (int j = 0; j < k; j++)
                        begin
                            for (int li = 0; li < NUM_LISTS; li++)
                            begin
                                q = int'(nbr_mem[li][p][j]);
                                if (q < n && mark_mem[q] == MARK_UNVISITED)
                                    mark_mem[q] = MARK_REJECTED;
                            end
                        end
                        mark_mem[p] = MARK_SELECTED;
                        r.picked = 1'b1;
                    end
                end
                default: ;
            endcase
            r.mark = mark_mem[p];
        end
        pending_marks.push_back(r);
    endfunction

    function automatic int pick_neighbor(input int p);
        case ($urandom_range(9))
            0: return p;
            1: return $urandom_range(MAX_POINTS - 1);
            default: return $urandom_range(eff_points() - 1);
        endcase
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 81; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 81; end
            default:   begin src_idle_pct = 7;  sink_stall_pct = 7;  end
        endcase
    endtask

    task automatic send_item(input cmd_t c, input int p, input int s, input int l,
                             input int nb);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= c;
        point          <= p[POINT_W-1:0];
        slot           <= s[SLOTF_W-1:0];
        list_select    <= l[LIST_W-1:0];
        neighbor_index <= nb[NBI_W-1:0];
        update_marks(c, p, s, l, nb);
        items_sent++;
        do @(posedge clk); while (!in_ready);
    endtask

    // A visit to an unvisited point reads every slot in use: load any that are blank
    task automatic visit_with_prime(input int p);
        int k;
        k = eff_nbrs();
        if (p < eff_points() && mark_mem[p] == MARK_UNVISITED)
        begin
            for (int j = 0; j < k; j++)
                for (int li = 0; li < NUM_LISTS; li++)
                    if (!nbr_written[li][p][j])
                        send_item(CMD_LOAD, p, j, li, pick_neighbor(p));
        end
        send_item(CMD_VISIT, p, $urandom_range(7), $urandom_range(3),
                  $urandom_range(MAX_POINTS - 1));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_marks.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DW-1:0];
        if (idx == REG_POINTS_IN_USE)
            pts_cfg = val[PIU_W-1:0];
        else
            nbrs_cfg = val[NIU_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        set_idling(IDLE_NONE);
        send_item(CMD_READ, 1023, 0, 0, 0);
        send_item(CMD_LOAD, 5, 3, 3, 1023);   // list 3 writes nothing
        send_item(CMD_LOAD, 1023, 7, 2, 1023);
        send_item(CMD_READ, 5, 7, 3, 0);
    endtask

    task automatic test_visit_rules();
        settle();
        write_reg(REG_POINTS_IN_USE, 4);
        write_reg(REG_NEIGHBORS_IN_USE, 1);
        // point 0: neighbour 1, itself, and one past the set
        send_item(CMD_LOAD, 0, 0, 0, 1);
        send_item(CMD_LOAD, 0, 0, 1, 0);
        send_item(CMD_LOAD, 0, 0, 2, 1000);
        send_item(CMD_LOAD, 1, 0, 0, 2);
        send_item(CMD_LOAD, 1, 0, 1, 3);
        send_item(CMD_LOAD, 1, 0, 2, 0);
        visit_with_prime(0);
        visit_with_prime(1);
        send_item(CMD_READ, 1, 0, 0, 0);
        visit_with_prime(0);
        visit_with_prime(5);
        send_item(CMD_READ, 4, 0, 0, 0);
        send_item(CMD_CLEAR, 2, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0);
        settle();
        write_reg(REG_NEIGHBORS_IN_USE, 0);
        visit_with_prime(2);
        visit_with_prime(3);
    endtask

    task automatic test_size_extremes();
        settle();
        write_reg(REG_POINTS_IN_USE, 0);
        send_item(CMD_READ, 0, 0, 0, 0);
        visit_with_prime(1023);
        settle();
        write_reg(REG_POINTS_IN_USE, 2047);
        write_reg(REG_NEIGHBORS_IN_USE, 15);
        send_item(CMD_CLEAR, 1023, 0, 0, 0);
        send_item(CMD_READ, 1023, 0, 0, 0);
    endtask

    // One data set: clear, then mostly visits in random order
    task automatic test_selection_run(input int budget);
        int n;
        int k;
        int start;
        int act;
        int p;
        cmd_t c;
        case ($urandom_range(7))
            0: n = 1;
            1: n = 2;
            2: n = $urandom_range(MAX_POINTS, 200);
            default: n = $urandom_range(40, 3);
        endcase
        if (n > 64)
            k = $urandom_range(2, 1);
        else
        begin
            case ($urandom_range(5))
                0: k = 0;
                1: k = $urandom_range(15, 9);
                2: k = MAX_NEIGHBORS;
                default: k = $urandom_range(7, 1);
            endcase
        end
        settle();
        write_reg(REG_POINTS_IN_USE, n);
        write_reg(REG_NEIGHBORS_IN_USE, k);
        send_item(CMD_CLEAR, $urandom_range(n - 1), 0, 0, 0);
        start = items_sent;
        while (items_sent - start < budget)
        begin
            act = $urandom_range(99);
            p = $urandom_range(n - 1);
            if (act < 65)
                visit_with_prime(p);
            else if (act < 77)
                send_item(CMD_READ, p, $urandom_range(7), $urandom_range(3), 0);
            else if (act < 87)
                send_item(CMD_LOAD, p, $urandom_range(7), $urandom_range(3),
                          pick_neighbor(p));
            else if (act < 97)
            begin
                c = cmd_t'($urandom_range(3));
                if (n < MAX_POINTS)
                    p = $urandom_range(MAX_POINTS - 1, n);
                if (c == CMD_VISIT)
                    visit_with_prime(p);
                else
                    send_item(c, p, $urandom_range(7), $urandom_range(3),
                              $urandom_range(MAX_POINTS - 1));
            end
            else
                send_item(CMD_CLEAR, p, 0, 0, 0);
        end
    endtask

    // Any command, any point, any field value
    task automatic test_mixed_commands(input int budget);
        int n;
        int start;
        int p;
        cmd_t c;
        case ($urandom_range(5))
            0: n = 0;
            1: n = 2047;
            2: n = MAX_POINTS;
            3: n = $urandom_range(2047, MAX_POINTS + 1);
            default: n = $urandom_range(MAX_POINTS - 1, 1);
        endcase
        settle();
        write_reg(REG_POINTS_IN_USE, n);
        write_reg(REG_NEIGHBORS_IN_USE,
                  (eff_points() > 64) ? $urandom_range(2) : $urandom_range(15));
        start = items_sent;
        while (items_sent - start < budget)
        begin
            c = cmd_t'($urandom_range(3));
            p = $urandom_range(MAX_POINTS - 1);
            if (c == CMD_VISIT)
                visit_with_prime(p);
            else
                send_item(c, p, $urandom_range(7), $urandom_range(3),
                          $urandom_range(MAX_POINTS - 1));
        end
    endtask

    // Result side: random back-pressure, checked against the shadow
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_marks.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending: point %0d status %0d new %0d",
                         $time, point_echo, status, newly_selected);
            end
            else
            begin
                want = pending_marks.pop_front();
                if (point_echo !== want.pt || status !== want.mark
                    || newly_selected !== want.picked)
                begin
                    errors++;
                    $display("%0t: expected point %0d status %0d new %0d, got %0d %0d %0d",
                             $time, want.pt, want.mark, want.picked,
                             point_echo, status, newly_selected);
                end
            end
        end
    end

    initial
    begin
        in_valid       <= 1'b0;
        cmd            <= CMD_LOAD;
        point          <= '0;
        slot           <= '0;
        list_select    <= '0;
        neighbor_index <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_POINTS_IN_USE;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        errors         = 0;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        pts_cfg        = MAX_POINTS;
        nbrs_cfg       = MAX_NEIGHBORS;
        for (int i = 0; i < MAX_POINTS; i++)
            mark_mem[i] = MARK_UNVISITED;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_visit_rules();
        test_size_extremes();
        for (int ph = 0; ph < 8; ph++)
        begin
            set_idling(ph % 4);
            test_selection_run(115);
        end
        set_idling(IDLE_SRC);
        test_mixed_commands(120);
        set_idling(IDLE_BOTH);
        test_mixed_commands(120);

        settle();
        if (pending_marks.size() != 0)
        begin
            errors += pending_marks.size();
            $display("%0t: %0d results never arrived", $time, pending_marks.size());
        end
        if (errors == 0)
            $display("greedy_independent_sample_select verification clean");
        else
            $display("greedy_independent_sample_select verification failed");
        $finish;
    end

endmodule

// ===== greedy_independent_sample_select.f =====
design/gis_pkg.sv
design/gis_ram.sv
design/greedy_independent_sample_select.sv
dv/tb_greedy_independent_sample_select.sv
